/* sv/lefd_pkg.sv */
// Shared types and constants for the LE / LEB128 field decoder.
package lefd_pkg;

  // Field kind codes (action / done_kind encoding)
  localparam logic [2:0] KindU8   = 3'd0;
  localparam logic [2:0] KindU16  = 3'd1;
  localparam logic [2:0] KindU32  = 3'd2;
  localparam logic [2:0] KindU64  = 3'd3;
  localparam logic [2:0] KindUleb = 3'd4;
  localparam logic [2:0] KindSleb = 3'd5;
  localparam logic [2:0] KindSkip = 3'd6;
  localparam logic [2:0] KindBad  = 3'd7;

  localparam int unsigned ValueW = 64;
  localparam int unsigned ShiftW = 7;
  localparam int unsigned CountW = 4;
  localparam int unsigned SkipW  = 16;

  localparam logic [ShiftW-1:0] LebStep   = 7'd7;
  localparam logic [ShiftW-1:0] ShiftCap  = 7'd70;
  localparam logic [ShiftW-1:0] ValueBits = 7'd64;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [2:0]       action;
    logic [SkipW-1:0] skip_length;
    logic             buffer_end;
  } item_t;

  typedef struct packed {
    logic [ValueW-1:0] field_value;
    logic              is_error;
    logic [2:0]        done_kind;
  } result_t;

endpackage

/* sv/lefd_in_if.sv */
// Byte input channel: valid/ready plus one tagged buffer byte per beat.
interface lefd_in_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 data_byte;
  logic [2:0]                 action;
  logic [lefd_pkg::SkipW-1:0] skip_length;
  logic                       buffer_end;

  modport source (output valid, data_byte, action, skip_length, buffer_end, input ready);
  modport sink   (input valid, data_byte, action, skip_length, buffer_end, output ready);
endinterface

/* sv/lefd_out_if.sv */
// Result output channel: valid/ready plus one decoded field per beat.
interface lefd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lefd_pkg::ValueW-1:0] field_value;
  logic                        is_error;
  logic [2:0]                  done_kind;

  modport source (output valid, field_value, is_error, done_kind, input ready);
  modport sink   (input valid, field_value, is_error, done_kind, output ready);
endinterface

/* sv/lefd_core.sv */
// Field state registers and the per-byte accumulate / complete logic.
module lefd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  lefd_pkg::item_t   item_i,
  output logic              res_vld_o,
  output lefd_pkg::result_t res_o
);

  logic [lefd_pkg::ValueW-1:0] acc_q, acc_d;
  logic [lefd_pkg::ShiftW-1:0] shift_q, shift_d;
  logic [lefd_pkg::CountW-1:0] taken_q, taken_d;
  logic [lefd_pkg::SkipW-1:0]  skip_q, skip_d;
  logic                        open_q, open_d;
  logic [2:0]                  kind_q, kind_d;

  logic                        start;
  logic [2:0]                  kind;
  logic [lefd_pkg::ValueW-1:0] acc0, acc1;
  logic [lefd_pkg::ShiftW-1:0] sh0, sh_sum, sh1;
  logic [lefd_pkg::CountW-1:0] bt0, bt1, need;
  logic [lefd_pkg::SkipW-1:0]  sk0, sk1;
  logic                        done;

  always_comb begin
    start  = !open_q;
    kind   = start ? item_i.action : kind_q;
    acc0   = start ? '0 : acc_q;
    sh0    = start ? '0 : shift_q;
    bt0    = start ? '0 : taken_q;
    if (!start) begin
      sk0 = skip_q;
    end else if (item_i.action == lefd_pkg::KindSkip) begin
      sk0 = (item_i.skip_length == '0) ? lefd_pkg::SkipW'(1) : item_i.skip_length;
    end else begin
      sk0 = '0;
    end

    acc1   = acc0;
    sh1    = sh0;
    bt1    = bt0;
    sk1    = sk0;
    done   = 1'b0;
    sh_sum = sh0 + lefd_pkg::LebStep;
    need   = lefd_pkg::CountW'(1) << kind[1:0];

    if (!kind[2]) begin
      // little-endian fixed width: byte lands at 8 * bytes_taken
      acc1 = acc0 | (lefd_pkg::ValueW'(item_i.data_byte) << {bt0[2:0], 3'b000});
      bt1  = bt0 + lefd_pkg::CountW'(1);
      done = (bt1 >= need);
    end else if (kind == lefd_pkg::KindUleb || kind == lefd_pkg::KindSleb) begin
      if (sh0 < lefd_pkg::ValueBits) begin
        acc1 = acc0 | (lefd_pkg::ValueW'(item_i.data_byte[6:0]) << sh0[5:0]);
      end
      sh1  = (sh_sum > lefd_pkg::ShiftCap) ? lefd_pkg::ShiftCap : sh_sum;
      done = !item_i.data_byte[7];
      if (done && kind == lefd_pkg::KindSleb && sh1 < lefd_pkg::ValueBits
          && item_i.data_byte[6]) begin
        acc1 = acc1 | ({lefd_pkg::ValueW{1'b1}} << sh1[5:0]);
      end
    end else begin
      sk1  = (sk0 != '0) ? sk0 - lefd_pkg::SkipW'(1) : sk0;
      done = (sk1 == '0);
    end
  end

  // next state and result
  always_comb begin
    acc_d     = acc_q;
    shift_d   = shift_q;
    taken_d   = taken_q;
    skip_d    = skip_q;
    open_d    = open_q;
    kind_d    = kind_q;
    res_vld_o = 1'b0;
    res_o     = '{field_value: '0, is_error: 1'b0, done_kind: kind};
    if (fire_i && !(start && item_i.action == lefd_pkg::KindBad)) begin
      if (done || item_i.buffer_end) begin
        res_vld_o = 1'b1;
        res_o.is_error = !done;
        res_o.field_value = (done && kind != lefd_pkg::KindSkip) ? acc1 : '0;
        acc_d   = '0;
        shift_d = '0;
        taken_d = '0;
        skip_d  = '0;
        open_d  = 1'b0;
        kind_d  = '0;
      end else begin
        acc_d   = acc1;
        shift_d = sh1;
        taken_d = bt1;
        skip_d  = sk1;
        open_d  = 1'b1;
        kind_d  = kind;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      shift_q <= '0;
      taken_q <= '0;
      skip_q  <= '0;
      open_q  <= 1'b0;
      kind_q  <= '0;
    end else begin
      acc_q   <= acc_d;
      shift_q <= shift_d;
      taken_q <= taken_d;
      skip_q  <= skip_d;
      open_q  <= open_d;
      kind_q  <= kind_d;
    end
  end

  a_shift_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_q <= lefd_pkg::ShiftCap)
    else $error("bit shift above cap");

  a_result_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o |=> !open_q && acc_q == '0)
    else $error("field still open after its result");

  a_open_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> kind_q != lefd_pkg::KindBad)
    else $error("open field with undefined kind");

endmodule

/* sv/le_and_leb128_field_decoder.sv */
// Top level: input register, field decode core and result register.
//
// Decodes a tagged debug-info byte stream, one byte per beat, into 64-bit
// field values: little-endian u8/u16/u32/u64, unsigned and signed LEB128
// (bits past 63 dropped, bytes still consumed; signed sign-extends from
// bit 6 of the last byte) and skips of skip_length bytes (zero taken as one)
// that close with a zero value. action and skip_length matter only on the
// first byte of a field; action 7 there drops the byte silently. A byte with
// buffer_end set inside an unfinished field gives an error beat (value 0,
// done_kind = open kind) and clears the decoder. Throughput is one byte per
// clock while results are taken: each byte is registered, then a single
// shift-or into the accumulator and the completion check run into the result
// register. A byte passes the input register, then the result register. The
// two registers advance together, so byte_i.ready drops only while a result
// waits on result_o and the next byte is held in the input register.
module le_and_leb128_field_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  lefd_in_if.sink    byte_i,
  lefd_out_if.source result_o
);

  // input register
  logic            in_vld_q;
  lefd_pkg::item_t in_q;
  // result register
  logic              res_vld_q;
  lefd_pkg::result_t res_q;

  logic              adv;
  logic              core_vld;
  lefd_pkg::result_t core_res;

  // move the held byte through the core when the result slot is free or being taken
  assign adv          = in_vld_q && (!res_vld_q || result_o.ready);
  assign byte_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_q <= '{data_byte:   byte_i.data_byte,
                action:      byte_i.action,
                skip_length: byte_i.skip_length,
                buffer_end:  byte_i.buffer_end};
    end
  end

  lefd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (adv),
    .item_i    (in_q),
    .res_vld_o (core_vld),
    .res_o     (core_res)
  );

  // result slot: loaded on advance, cleared when taken and nothing replaces it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= core_vld;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && core_vld) begin
      res_q <= core_res;
    end
  end

  assign result_o.valid       = res_vld_q;
  assign result_o.field_value = res_q.field_value;
  assign result_o.is_error    = res_q.is_error;
  assign result_o.done_kind   = res_q.done_kind;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.is_error |-> res_q.field_value == '0)
    else $error("error beat with nonzero value");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_q))
    else $error("held byte lost or changed");

  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> res_q.done_kind != lefd_pkg::KindBad)
    else $error("result with undefined kind");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for le_and_leb128_field_decoder: directed and random byte streams.
module tb_top;
  import lefd_pkg::*;

  // Generous bound: ~850 beats with their worst gaps and stalls, taken several times over.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 40;

  logic clk_i;
  logic rst_ni;

  lefd_in_if  byte_if ();
  lefd_out_if result_if ();

  le_and_leb128_field_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  // Idle knobs, changed per test. Each beat draws a wait from 0 up to these.
  int unsigned src_gap_max;
  int unsigned snk_stall_max;

  int unsigned mismatch_count;
  int unsigned bytes_taken_count;   // beats that the decoder did not simply drop
  int unsigned cycle_count;

  // Decoded fields the decoder owes us, oldest first.
  result_t pending_fields[$];
  result_t want;

  // Shadow copy of the decoder state.
  logic [ValueW-1:0] acc_q;
  logic [ShiftW-1:0] shift_q;
  logic [CountW-1:0] taken_q;
  logic [SkipW-1:0]  skip_left_q;
  logic              field_open_q;
  logic [2:0]        open_kind_q;

  // ---------------------------------------------------------------------------
  // Clock and cycle guard
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Field predictor
  // ---------------------------------------------------------------------------
  task automatic clear_shadow();
    acc_q        = '0;
    shift_q      = '0;
    taken_q      = '0;
    skip_left_q  = '0;
    field_open_q = 1'b0;
    open_kind_q  = KindU8;
  endtask

  // Feed one accepted byte beat through the shadow decoder. Queues the field
  // it closes, if any. 'used' is low when an idle decoder drops the byte.
  task automatic decode_byte(input item_t beat, output bit used);
    logic [7:0]        b;
    logic              closed;
    logic [ValueW-1:0] value;
    int unsigned       need;
    result_t           res;
    b      = beat.data_byte;
    closed = 1'b0;
    value  = '0;
    used   = 1'b1;

    // Opening byte: kind and skip length are latched only here.
    if (!field_open_q) begin
      if (beat.action == KindBad) begin
        used = 1'b0;
        return;
      end
      field_open_q = 1'b1;
      open_kind_q  = beat.action;
      acc_q        = '0;
      shift_q      = '0;
      taken_q      = '0;
      if (beat.action == KindSkip)
        skip_left_q = (beat.skip_length == '0) ? SkipW'(1) : beat.skip_length;
      else
        skip_left_q = '0;
    end

    if (open_kind_q <= KindU64) begin
      // Little-endian: byte n lands at bit 8n.
      need    = 1 << open_kind_q;
      acc_q   = acc_q | ({56'd0, b} << (8 * taken_q));
      taken_q = taken_q + 1'b1;
      if (taken_q >= need) begin
        closed = 1'b1;
        value  = acc_q;
      end
    end else if (open_kind_q == KindUleb || open_kind_q == KindSleb) begin
      // Payload bits past 63 fall off; shift count saturates.
      if (shift_q < ValueBits)
        acc_q = acc_q | ({57'd0, b[6:0]} << shift_q);
      shift_q = (shift_q + LebStep > ShiftCap) ? ShiftCap : shift_q + LebStep;
      if (!b[7]) begin
        closed = 1'b1;
        if (open_kind_q == KindSleb && shift_q < ValueBits && b[6])
          acc_q = acc_q | ({ValueW{1'b1}} << shift_q);
        value = acc_q;
      end
    end else begin
      if (skip_left_q != '0)
        skip_left_q = skip_left_q - 1'b1;
      if (skip_left_q == '0)
        closed = 1'b1;
    end

    if (closed) begin
      res.field_value = value;
      res.is_error    = 1'b0;
      res.done_kind   = open_kind_q;
      pending_fields.push_back(res);
      clear_shadow();
    end else if (beat.buffer_end) begin
      // Buffer ran out mid-field: error beat carries the open kind.
      res.field_value = '0;
      res.is_error    = 1'b1;
      res.done_kind   = open_kind_q;
      pending_fields.push_back(res);
      clear_shadow();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte source: one beat per call. Drives at negedge, samples at posedge.
  // valid stays high across back-to-back beats.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] data, input logic [2:0] act,
                           input logic [SkipW-1:0] slen, input logic last);
    int unsigned gap;
    item_t       beat;
    bit          used;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      byte_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid       = 1'b1;
    byte_if.data_byte   = data;
    byte_if.action      = act;
    byte_if.skip_length = slen;
    byte_if.buffer_end  = last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    beat.data_byte   = data;
    beat.action      = act;
    beat.skip_length = slen;
    beat.buffer_end  = last;
    decode_byte(beat, used);
    if (used)
      bytes_taken_count++;
  endtask

  // One well-formed field of the given kind with random content. With 'chop'
  // the buffer ends before a multi-byte field does. Non-opening bytes carry
  // random action and skip_length, which the decoder must ignore.
  task automatic send_field(input logic [2:0] kind, input bit chop);
    int unsigned      n;
    int unsigned      cut;
    int unsigned      i;
    logic [SkipW-1:0] slen;
    logic [7:0]       b;
    logic [2:0]       act;
    logic             last;
    bit               cut_here;
    slen     = SkipW'($urandom_range(0, 65535));
    cut_here = chop;
    if (kind <= KindU64) begin
      n = 1 << kind;
    end else if (kind == KindUleb || kind == KindSleb) begin
      // Mostly short; some long enough to overflow and saturate the shift.
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
    end else begin
      if ($urandom_range(0, 7) == 0) begin
        slen     = SkipW'($urandom_range(16, 65535));   // long skip, always cut short
        cut_here = 1'b1;
      end else begin
        slen = SkipW'($urandom_range(0, 12));
      end
      n = (slen == '0) ? 1 : slen;
    end
    if (n < 2)
      cut_here = 1'b0;
    cut = cut_here ? $urandom_range(0, (n - 2 < 15) ? n - 2 : 15) : n - 1;

    for (i = 0; i <= cut; i++) begin
      b = 8'($urandom);
      if (kind == KindUleb || kind == KindSleb)
        b[7] = (i != n - 1);
      if (i == cut)
        last = cut_here ? 1'b1 : ($urandom_range(0, 3) == 0);
      else
        last = 1'b0;
      act = 3'($urandom_range(0, 7));
      if (i == 0)
        send_byte(b, kind, slen, last);
      else
        send_byte(b, act, SkipW'($urandom), last);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: per beat, hold ready low for a drawn number of cycles.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, snk_stall_max);
      @(negedge clk_i);
      if (stall > 0) begin
        result_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready = 1'b1;
      @(posedge clk_i);
      while (!result_if.valid) @(posedge clk_i);
    end
  end

  // Result checker: every accepted beat against the oldest queued field.
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_fields.size() == 0) begin
        $error("unexpected result beat: field_value=%h is_error=%b done_kind=%0d",
               result_if.field_value, result_if.is_error, result_if.done_kind);
        mismatch_count++;
      end else begin
        want = pending_fields.pop_front();
        if (result_if.field_value !== want.field_value) begin
          $error("field_value: expected %h, got %h", want.field_value,
                 result_if.field_value);
          mismatch_count++;
        end
        if (result_if.is_error !== want.is_error) begin
          $error("is_error: expected %b, got %b", want.is_error, result_if.is_error);
          mismatch_count++;
        end
        if (result_if.done_kind !== want.done_kind) begin
          $error("done_kind: expected %0d, got %0d", want.done_kind,
                 result_if.done_kind);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fixed-width little-endian fields.
  task automatic test_le_fields();
    src_gap_max   = 3;
    snk_stall_max = 3;
    // u8 at max, closing exactly on the buffer's last byte: normal result.
    send_byte(8'hff, KindU8, 16'hffff, 1'b1);
    // u16; the second byte's action 7 must not disturb the open field.
    send_byte(8'h00, KindU16, 16'h0000, 1'b0);
    send_byte(8'h80, KindBad, 16'h0000, 1'b0);
    // u32; kind changes on the later bytes are ignored too.
    send_byte(8'h78, KindU32, 16'h5a5a, 1'b0);
    send_byte(8'h56, KindU8, 16'h0000, 1'b0);
    send_byte(8'h34, KindUleb, 16'h0000, 1'b0);
    send_byte(8'h12, KindSkip, 16'h0001, 1'b0);
    // u64 cut off after two bytes: error beat, decoder back to idle.
    send_byte(8'hff, KindU64, 16'h0000, 1'b0);
    send_byte(8'hff, KindU64, 16'h0000, 1'b1);
  endtask

  // LEB128: single-byte values, sign extension, and an over-long encoding.
  task automatic test_leb_fields();
    int unsigned i;
    src_gap_max   = 2;
    snk_stall_max = 5;
    send_byte(8'h7f, KindUleb, 16'h0000, 1'b0);   // 127
    send_byte(8'h40, KindSleb, 16'h0000, 1'b0);   // -64
    // Ten-byte sleb: shift reaches the cap, top payload bits dropped, no extension.
    for (i = 0; i < 10; i++)
      send_byte((i == 9) ? 8'h7f : 8'hff, (i == 0) ? KindSleb : KindU8, 16'h0000, 1'b0);
  endtask

  // Skips and the undefined kind.
  task automatic test_skip_and_bad_kind();
    src_gap_max   = 4;
    snk_stall_max = 2;
    send_byte(8'haa, KindSkip, 16'h0000, 1'b0);   // zero length counts as one
    send_byte(8'h55, KindSkip, 16'hffff, 1'b0);   // longest skip, cut short
    send_byte(8'h00, KindSkip, 16'h0000, 1'b1);
    send_byte(8'h3c, KindBad, 16'h1234, 1'b1);    // dropped, no error despite end
  endtask

  // Random mix: mostly whole fields, some cut short, some raw noise beats.
  task automatic test_random_stream(input int unsigned n_items,
                                    input int unsigned gap_max,
                                    input int unsigned stall_max);
    int unsigned start;
    logic [2:0]  kind;
    src_gap_max   = gap_max;
    snk_stall_max = stall_max;
    start         = bytes_taken_count;
    while (bytes_taken_count - start < n_items) begin
      kind = 3'($urandom_range(0, 6));
      case ($urandom_range(0, 9))
        0: begin
          send_byte(8'($urandom), 3'($urandom_range(0, 7)), SkipW'($urandom),
                    $urandom_range(0, 3) == 0);
        end
        1: begin
          send_field(kind, 1'b1);
        end
        default: begin
          send_field(kind, 1'b0);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni              = 1'b0;
    byte_if.valid       = 1'b0;
    byte_if.data_byte   = '0;
    byte_if.action      = KindU8;
    byte_if.skip_length = '0;
    byte_if.buffer_end  = 1'b0;
    src_gap_max         = 0;
    snk_stall_max       = 0;
    mismatch_count      = 0;
    bytes_taken_count   = 0;
    cycle_count         = 0;
    clear_shadow();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_le_fields();
    test_leb_fields();
    test_skip_and_bad_kind();
    test_random_stream(200, 0, 0);     // full rate, no idling anywhere
    test_random_stream(200, 18, 0);    // source gaps
    test_random_stream(200, 0, 18);    // sink back-pressure
    test_random_stream(200, 18, 18);   // both sides idle

    @(negedge clk_i);
    byte_if.valid = 1'b0;

    // Drain, then give a stray extra beat time to show up.
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
sv/lefd_pkg.sv
sv/lefd_in_if.sv
sv/lefd_out_if.sv
sv/lefd_core.sv
sv/le_and_leb128_field_decoder.sv
tb/sv/tb_top.sv
